// ===== rtl/core/bb3_pkg.sv =====
// Package for the 3x3 box blur core: widths, register indexes, reset values
// and the types passed between the core's submodules.
// No dependencies; every other file of the core imports it.
package bb3_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Depth of the output queue that decouples the stream from a stalled receiver.
  localparam int OUT_DEPTH = 8;

  // Division by nine as a multiplication by a rounded-up reciprocal; exact
  // for every sum of nine 8-bit pixels.
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

  typedef logic [PIX_W-1:0] pix_t;

  // Window rows: 0 is two lines back, 2 the current line; column 2 is newest.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    pix_t px;
    logic has_out;
    logic interior;
    logic last;
  } bb3_item_t;

  typedef struct packed {
    logic interior;
    logic last;
  } bb3_tag_t;

  typedef struct packed {
    pix_t pixel;
    logic last;
  } bb3_res_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } bb3_busy_t;

endpackage

// ===== rtl/core/bb3_stream_if.sv =====
// Valid/ready stream interfaces for the input and result channels of the core.
// Depends on bb3_pkg for the payload widths.
interface bb3_in_if;
  import bb3_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_in;
  logic drain;

  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface bb3_out_if;
  import bb3_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/core/bb3_ctrl.sv =====
// Configuration registers and raster position counters of the box blur core.
// Classifies each accepted word and issues the line store access.
// Depends on bb3_pkg.
module bb3_ctrl #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           take,
  input  bb3_pkg::pix_t                  pixel_in,
  input  logic                           drain,
  output logic                           issue,
  output logic [CW-1:0]                  addr,
  output bb3_pkg::bb3_item_t             item
);
  import bb3_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [CW-1:0]  in_col_r,  in_col_nxt;
  logic [IRW-1:0] in_row_r,  in_row_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [ORW-1:0] out_row_r, out_row_nxt;

  logic row_full;
  logic ignore;
  logic col_wrap;
  logic out_col_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A zero dimension counts as one and anything above the maximum as the maximum.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  always_comb begin
    row_full     = 32'(in_row_r) >= 32'(h_eff);
    ignore       = drain && !row_full;
    issue        = take && !ignore;
    addr         = in_col_r;
    col_wrap     = (32'(in_col_r) + 1) >= 32'(w_eff);
    out_col_wrap = (32'(out_col_r) + 1) >= 32'(w_eff);

    item.px       = (drain || row_full) ? '0 : pixel_in;
    // Nothing leaves until the word one line and one pixel later has arrived.
    item.has_out  = !((in_row_r == '0) || (in_row_r == IRW'(1) && in_col_r == '0));
    item.interior = (out_row_r != '0) && ((32'(out_row_r) + 2) <= 32'(h_eff)) &&
                    (out_col_r != '0) && ((32'(out_col_r) + 2) <= 32'(w_eff));
    item.last     = ((32'(out_row_r) + 1) >= 32'(h_eff)) && out_col_wrap;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (issue) begin
      if (item.has_out && item.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        in_col_nxt = col_wrap ? '0 : in_col_r + CW'(1);
        in_row_nxt = col_wrap ? in_row_r + IRW'(1) : in_row_r;
        if (item.has_out) begin
          out_col_nxt = out_col_wrap ? '0 : out_col_r + CW'(1);
          out_row_nxt = out_col_wrap ? out_row_r + ORW'(1) : out_row_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && item.has_out && item.last) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("position counters not rewound after the last pixel of a frame");
`endif

endmodule

// ===== rtl/core/bb3_line_mem.sv =====
// Line store memory holding the two previous lines, with the 3x3 window.
// Reads a column, shifts the window and writes the column back in the next cycle.
// Depends on bb3_pkg.
module bb3_line_mem #(
  parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
  localparam int CW       = $clog2(MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               issue,
  input  logic [CW-1:0]      addr,
  input  bb3_pkg::bb3_item_t item,
  output logic               win_valid,
  output bb3_pkg::bb3_tag_t  win_tag,
  output bb3_pkg::win_t      win,
  output bb3_pkg::bb3_busy_t busy
);
  import bb3_pkg::*;

  // Each entry holds {two lines back, one line back} for its column.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               fwd_v_r;

  logic               s1_v_r;
  logic [CW-1:0]      s1_addr_r;
  bb3_item_t          s1_item_r;
  logic               s2_v_r;
  bb3_tag_t           s2_tag_r;
  win_t               win_r;

  logic [2*PIX_W-1:0] col_data;
  pix_t               up_px;
  pix_t               mid_px;
  logic [2*PIX_W-1:0] wr_data;

  always_comb begin
    col_data = fwd_v_r ? fwd_data_r : rd_q_r;
    up_px    = col_data[2*PIX_W-1:PIX_W];
    mid_px   = col_data[PIX_W-1:0];
    wr_data  = {mid_px, s1_item_r.px};
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_addr_r] <= wr_data;
    end
    if (issue) begin
      rd_q_r <= mem[addr];
    end
  end

  // A read of the column being written back in the same cycle sees the old
  // entry, so the new one is carried across instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= issue && s1_v_r && (addr == s1_addr_r);
    end
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r && s1_item_r.has_out;
    end
    s1_addr_r         <= addr;
    s1_item_r         <= item;
    s2_tag_r.interior <= s1_item_r.interior;
    s2_tag_r.last     <= s1_item_r.last;
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= s1_item_r.px;
    end
  end

  assign win_valid = s2_v_r;
  assign win_tag   = s2_tag_r;
  assign win       = win_r;
  assign busy      = {s1_v_r, s2_v_r};

endmodule

// ===== rtl/core/bb3_mean.sv =====
// Window sum and division by nine, with the border pass-through selection.
// Two register stages: the sum, then the scaled quotient into the output queue.
// Depends on bb3_pkg.
module bb3_mean (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              win_valid,
  input  bb3_pkg::bb3_tag_t win_tag,
  input  bb3_pkg::win_t     win,
  output logic              busy,
  output logic              push,
  output bb3_pkg::bb3_res_t push_data
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         sum_r;
  pix_t                     centre_r;
  bb3_tag_t                 tag_r;
  logic                     s3_v_r;
  logic [SUM_W+RECIP_W-1:0] prod;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + SUM_W'(win[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= win_valid;
    end
    sum_r    <= sum;
    centre_r <= win[1][1];
    tag_r    <= win_tag;
  end

  always_comb begin
    prod            = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(RECIP_NINE);
    push            = s3_v_r;
    push_data.pixel = tag_r.interior ? prod[RECIP_SHIFT +: PIX_W] : centre_r;
    push_data.last  = tag_r.last;
  end

  assign busy = s3_v_r;

endmodule

// ===== rtl/core/bb3_out_fifo.sv =====
// Output queue of result words, driving the result channel.
// Its fill level is returned for the input credit check. Depends on bb3_pkg.
module bb3_out_fifo #(
  parameter int DEPTH = bb3_pkg::OUT_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bb3_pkg::bb3_res_t push_data,
  output logic [NW-1:0]     count,
  bb3_out_if.source         out_ch
);
  import bb3_pkg::*;

  bb3_res_t       q_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]  count_r;
  logic           pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_comb begin
    out_ch.valid      = count_r != '0;
    out_ch.pixel_out  = q_r[rd_ptr_r].pixel;
    out_ch.frame_last = q_r[rd_ptr_r].last;
  end

  assign count = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (32'(count_r) < DEPTH || pop))
    else $error("result word pushed into a full output queue");
`endif

endmodule

// ===== rtl/core/box_blur_3x3_core.sv =====
// 3x3 box blur for 8-bit grey frames streamed in raster order.
// Input words carry pixel_in and drain; result words carry pixel_out and
// frame_last. A word moves when valid and ready are both high at a clock edge.
// Frame size comes from the frame_width and frame_height registers, written
// through cfg_we/cfg_index/cfg_wdata while the stream is idle.
// The result for pixel k leaves with the acceptance of word k+W+1 and passes
// the s1, s2, s3 and queue registers to the result channel. After the last
// pixel of a frame, W+1 drain words flush the remaining results; a drain word
// arriving earlier is taken and dropped. frame_last marks the final pixel.
// One input word per cycle is sustained unless the credit check stalls input:
// the line store is read, and written back next cycle, on separate ports.
// An 8-word output queue, credited against the three words in the pipeline,
// lets input continue while results wait; input stalls once the queue and
// the three pipeline stages together hold eight words.
// Reset clears the counters, the pipeline and the queue and restores a 640x480
// frame; the line store contents need no clearing.
// Depends on bb3_pkg and bb3_stream_if.
module box_blur_3x3_core #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata,
  bb3_in_if.sink                        in_ch,
  bb3_out_if.source                     out_ch
);
  import bb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(OUT_DEPTH + 1);

  logic          take;
  logic          issue;
  logic [CW-1:0] addr;
  bb3_item_t     item;
  logic          win_valid;
  bb3_tag_t      win_tag;
  win_t          win;
  bb3_busy_t     lm_busy;
  logic          mean_busy;
  logic          push;
  bb3_res_t      push_data;
  logic [NW-1:0] fifo_count;
  logic [NW:0]   committed;

  // Every word in the pipeline is counted as if it will produce a result.
  assign committed = (NW+1)'(fifo_count) + (NW+1)'(lm_busy.s1) +
                     (NW+1)'(lm_busy.s2) + (NW+1)'(mean_busy);
  assign in_ch.ready = 32'(committed) < OUT_DEPTH;
  assign take        = in_ch.valid && in_ch.ready;

  bb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .pixel_in  (in_ch.pixel_in),
    .drain     (in_ch.drain),
    .issue     (issue),
    .addr      (addr),
    .item      (item)
  );

  bb3_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .addr      (addr),
    .item      (item),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .win       (win),
    .busy      (lm_busy)
  );

  bb3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_valid (win_valid),
    .win_tag   (win_tag),
    .win       (win),
    .busy      (mean_busy),
    .push      (push),
    .push_data (push_data)
  );

  bb3_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(committed) <= OUT_DEPTH)
    else $error("more words in flight than the output queue can hold");
`endif

endmodule
